@@ rtl/palette_recolor_pixel_defines.svh @@
// Assertion macros for the palette recolor block.
`ifndef PALETTE_RECOLOR_PIXEL_DEFINES_SVH
`define PALETTE_RECOLOR_PIXEL_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRP_ASSERT(lbl, prop, msg)
`define PRP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/prp_pkg.sv @@
// Types and constants shared by the palette recolor block.
`default_nettype none
package prp_pkg;

  localparam int CHAN_W      = 8;
  localparam int SIZE_W      = 9;
  localparam int PAL_SIDE    = 256;
  localparam int PAL_ADDR_W  = 16;
  localparam int PAL_ENTRY_W = 24;
  localparam int PROD_W      = 17;
  localparam int CFG_INDEX_W = 2;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_RECOLOR = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_HEIGHT = 2'd1;

  typedef struct packed {
    logic              operation;
    logic [CHAN_W-1:0] entry_column;
    logic [CHAN_W-1:0] entry_row;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] alpha;
  } pixel_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_alpha;
    logic              no_match;
  } pixel_out_t;

endpackage
`default_nettype wire

@@ rtl/prp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module prp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ rtl/palette_recolor_pixel.sv @@
// Top level of the palette recolor block: palette store, coordinate search, result beat.
// Load beats write one palette entry and leave the block idle. A pixel beat with alpha
// zero goes straight to the finish state. Any other pixel runs a coordinate search
// that walks candidate index i from 0 with one shared accumulator of 255*(2i+1),
// testing red against the width and green against the height each cycle and stopping
// once both have matched or the last index is reached. Setup precedes the search; a
// match inside the palette then passes the read and fetch states, and every pixel ends
// in the finish state. in_ready is low in every state but idle. Configuration writes
// are taken in any cycle. The palette holds no reset value and needs no clearing pass:
// an entry must be loaded before a pixel looks it up.
`default_nettype none
`include "palette_recolor_pixel_defines.svh"
module palette_recolor_pixel #(
  parameter int COORD_RANGE = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire prp_pkg::pixel_in_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output prp_pkg::pixel_out_t                     out_data,
  input  wire logic                               cfg_wr_en,
  input  wire logic [prp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [prp_pkg::SIZE_W-1:0]         cfg_wdata
);
  import prp_pkg::*;

  localparam int IW     = $clog2(COORD_RANGE);
  localparam int NUM_W  = $clog2(255 * (2 * COORD_RANGE + 1) + 1);
  localparam int CMP_W  = ((NUM_W > PROD_W) ? NUM_W : PROD_W) + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(COORD_RANGE - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SETUP  = 6'b000010,
    S_SEARCH = 6'b000100,
    S_READ   = 6'b001000,
    S_FETCH  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [SIZE_W-1:0] palette_width, palette_height;
  logic [SIZE_W-1:0] w_n, h_n;

  logic [CHAN_W-1:0] res_blue, res_green, res_red, res_alpha;
  logic              res_no_match;

  logic [PROD_W-1:0] lo_r, lo_g;
  logic [NUM_W-1:0]  num;
  logic [IW-1:0]     idx;
  logic [IW-1:0]     x, y;
  logic              found_r, found_g;

  logic              match_r, match_g, fr, fg, done, in_range;
  logic [IW-1:0]     xn, yn;
  logic [CMP_W-1:0]  num_ext, w_ext, h_ext, lo_r_ext, lo_g_ext;

  logic                   accept, load_wr;
  logic [PAL_ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
  logic [PAL_ENTRY_W-1:0] ram_wr_data, ram_rd_data;
  logic                   out_load;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_width  <= SIZE_W'(PAL_SIDE);
      palette_height <= SIZE_W'(PAL_SIDE);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PALETTE_WIDTH:  palette_width  <= cfg_wdata;
        REG_PALETTE_HEIGHT: palette_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (palette_width == '0) w_n = SIZE_W'(1);
    else if (palette_width > SIZE_W'(PAL_SIDE)) w_n = SIZE_W'(PAL_SIDE);
    else w_n = palette_width;
    if (palette_height == '0) h_n = SIZE_W'(1);
    else if (palette_height > SIZE_W'(PAL_SIDE)) h_n = SIZE_W'(PAL_SIDE);
    else h_n = palette_height;
  end

  // palette store
  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign load_wr     = accept && (in_data.operation == OP_LOAD);
  assign ram_wr_addr = {in_data.entry_row, in_data.entry_column};
  assign ram_wr_data = {in_data.red, in_data.green, in_data.blue};
  assign ram_rd_addr = {CHAN_W'(y), CHAN_W'(x)};

  prp_ram #(
    .WIDTH(PAL_ENTRY_W),
    .DEPTH(PAL_SIDE * PAL_SIDE)
  ) u_palette (
    .clk    (clk),
    .wr_en  (load_wr),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // match test: (2c-1)n < 255(2i+1) <= (2c+1)n, with lo = 2cn
  assign num_ext  = CMP_W'(num);
  assign w_ext    = CMP_W'(w_n);
  assign h_ext    = CMP_W'(h_n);
  assign lo_r_ext = CMP_W'(lo_r);
  assign lo_g_ext = CMP_W'(lo_g);
  assign match_r  = (num_ext + w_ext > lo_r_ext) && (num_ext <= lo_r_ext + w_ext);
  assign match_g  = (num_ext + h_ext > lo_g_ext) && (num_ext <= lo_g_ext + h_ext);
  assign fr       = found_r || match_r;
  assign fg       = found_g || match_g;
  assign xn       = found_r ? x : idx;
  assign yn       = found_g ? y : idx;
  assign done     = (fr && fg) || (idx == LAST_IDX);
  assign in_range = (SIZE_W'(xn) < w_n) && (SIZE_W'(yn) < h_n);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (in_data.operation == OP_RECOLOR)) begin
          state_next = (in_data.alpha == '0) ? S_FINISH : S_SETUP;
        end
      end
      S_SETUP:  state_next = S_SEARCH;
      S_SEARCH: begin
        if (done) state_next = (fr && fg && in_range) ? S_READ : S_FINISH;
      end
      S_READ:   state_next = S_FETCH;
      S_FETCH:  state_next = S_FINISH;
      S_FINISH: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_blue     <= in_data.blue;
          res_green    <= in_data.green;
          res_red      <= in_data.red;
          res_alpha    <= in_data.alpha;
          res_no_match <= 1'b0;
        end
      end
      S_SETUP: begin
        lo_r    <= PROD_W'({res_red, 1'b0}) * PROD_W'(w_n);
        lo_g    <= PROD_W'({res_green, 1'b0}) * PROD_W'(h_n);
        num     <= NUM_W'(255);
        idx     <= '0;
        found_r <= 1'b0;
        found_g <= 1'b0;
      end
      S_SEARCH: begin
        num     <= num + NUM_W'(510);
        idx     <= idx + IW'(1);
        found_r <= fr;
        found_g <= fg;
        x       <= xn;
        y       <= yn;
        if (done && !(fr && fg && in_range)) res_no_match <= 1'b1;
      end
      S_FETCH: begin
        res_blue  <= ram_rd_data[CHAN_W-1:0];
        res_green <= ram_rd_data[2*CHAN_W-1:CHAN_W];
        res_red   <= ram_rd_data[3*CHAN_W-1:2*CHAN_W];
      end
      default: ;
    endcase
  end

  // result beat
  assign out_load = (state == S_FINISH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.out_blue  <= res_blue;
      out_data.out_green <= res_green;
      out_data.out_red   <= res_red;
      out_data.out_alpha <= res_alpha;
      out_data.no_match  <= res_no_match;
    end
  end

  `PRP_ASSERT(a_read_in_palette,
    (state == S_READ) |-> (found_r && found_g && SIZE_W'(x) < w_n && SIZE_W'(y) < h_n),
    "palette lookup outside the palette")
  `PRP_ASSERT(a_beat_from_finish,
    $rose(out_valid) |-> ($past(state) == S_FINISH),
    "result beat raised outside finish")
  `PRP_ASSERT(a_finish_delivers,
    ((state == S_FINISH) && (!out_valid || out_ready)) |=> (out_valid && state == S_IDLE),
    "finish did not deliver its beat")
  `PRP_ASSERT_ALWAYS(a_reset_idle,
    rst |=> (state == S_IDLE && !out_valid),
    "reset did not return to idle")

endmodule
`default_nettype wire
